[rtl/assert_macros.svh]
// Assertion macros shared by the BLZ decompressor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BLZ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BLZ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/blz_pkg.sv]
// Shared constants and types for the BLZ decompressor.
`timescale 1ns / 1ps
package blz_pkg;

	localparam int HIST_DEPTH = 8192;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int SUM_W      = HIST_AW + 1;
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

	localparam int LEN_W        = 5;
	localparam int DIST_W       = 13;
	localparam int LEN_BIAS     = 3;
	// distance minus one: the source sits that far above the current write_pos
	localparam int DIST_M1_BIAS = 2;

	typedef struct packed {
		logic              start;
		logic              copy;
		logic [7:0]        lit;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic [DIST_W-1:0] dist_m1;
	} blz_cmd_t;

endpackage

[rtl/blz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module blz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/blz_parse.sv]
// Token parser: flag byte tracking, literal and copy token decode.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module blz_parse
	import blz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] comp_byte,
	input  logic       final_in,
	output blz_cmd_t   cmd
);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_COPY_LO
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] flag_q, flag_n;
	logic [3:0] bits_left_q, bits_left_n;
	logic [7:0] token_high_q, token_high_n;
	logic       consume;
	logic [3:0] bits_dec;

	always_comb begin
		cmd          = '0;
		phase_n      = phase_q;
		flag_n       = flag_q;
		bits_left_n  = bits_left_q;
		token_high_n = token_high_q;
		consume      = 1'b0;
		bits_dec     = (bits_left_q != 4'd0) ? bits_left_q - 4'd1 : 4'd0;

		case (phase_q)
			PH_LIT: begin
				if (!flag_q[7]) begin
					cmd.start = fire;
					cmd.copy  = 1'b0;
					cmd.lit   = comp_byte;
					cmd.last  = final_in;
					cmd.len   = LEN_W'(1);
					consume   = 1'b1;
				end else if (final_in) begin
					// stream ends inside a copy token: drop it
					flag_n      = '0;
					bits_left_n = '0;
					phase_n     = PH_FLAG;
				end else begin
					token_high_n = comp_byte;
					phase_n      = PH_COPY_LO;
				end
			end
			PH_COPY_LO: begin
				cmd.start   = fire;
				cmd.copy    = 1'b1;
				cmd.last    = final_in;
				cmd.len     = LEN_W'(token_high_q[7:4]) + LEN_W'(LEN_BIAS);
				cmd.dist_m1 = DIST_W'({token_high_q[3:0], comp_byte}) + DIST_W'(DIST_M1_BIAS);
				consume     = 1'b1;
			end
			default: begin
				if (final_in) begin
					flag_n      = '0;
					bits_left_n = '0;
					phase_n     = PH_FLAG;
				end else begin
					flag_n      = comp_byte;
					bits_left_n = 4'd8;
					phase_n     = PH_LIT;
				end
			end
		endcase

		if (consume) begin
			flag_n      = {flag_q[6:0], 1'b0};
			bits_left_n = bits_dec;
			if (final_in) begin
				flag_n      = '0;
				bits_left_n = '0;
				phase_n     = PH_FLAG;
			end else if (bits_dec == 4'd0) begin
				phase_n = PH_FLAG;
			end else begin
				phase_n = PH_LIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FLAG;
			flag_q       <= '0;
			bits_left_q  <= '0;
			token_high_q <= '0;
		end else if (fire) begin
			phase_q      <= phase_n;
			flag_q       <= flag_n;
			bits_left_q  <= bits_left_n;
			token_high_q <= token_high_n;
		end
	end

	`BLZ_ASSERT_IMPL(a_bits_range, 1'b1, bits_left_q <= 4'd8, "bits_left above eight")
	`BLZ_ASSERT_IMPL(a_lit_has_bits, phase_q == PH_LIT, bits_left_q != 4'd0, "token phase with no flag bits")

endmodule

[rtl/blz_engine.sv]
// Output sequencer: emits literals and walks copy tokens through the history RAM.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module blz_engine
	import blz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  blz_cmd_t   cmd,
	output logic       idle,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       res_valid,
	input  logic       res_ready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic                copy_q;
	logic [7:0]          lit_q;
	logic                last_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [DIST_W-1:0]   dist_q;
	logic                hit_q;
	logic [HIST_AW-1:0]  write_pos_q;
	logic [FILL_W-1:0]   fill_q;
	logic                res_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;

	logic [HIST_AW-1:0]  nwp;
	logic [SUM_W-1:0]    src_sum;
	logic [HIST_AW-1:0]  src_addr;
	logic                src_hit;
	logic [7:0]          rd_data;
	logic [7:0]          emit_data;
	logic                emit_fire;

	always_comb begin
		nwp      = (write_pos_q == '0) ? HIST_AW'(HIST_DEPTH - 1) : write_pos_q - 1'b1;
		src_sum  = {1'b0, write_pos_q} + SUM_W'(dist_q);
		src_addr = (src_sum >= SUM_W'(HIST_DEPTH)) ?
			HIST_AW'(src_sum - SUM_W'(HIST_DEPTH)) : src_sum[HIST_AW-1:0];
		// slots never written since reset read as zero
		src_hit   = FILL_W'(dist_q) < fill_q;
		emit_data = copy_q ? (hit_q ? rd_data : 8'h00) : lit_q;
		emit_fire = (state_q == S_EMIT) && (!res_valid_q || res_ready);
	end

	blz_ram #(
		.WIDTH(8),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (emit_fire),
		.waddr(nwp),
		.wdata(emit_data),
		.re   (state_q == S_READ),
		.raddr(src_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			copy_q      <= 1'b0;
			lit_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			dist_q      <= '0;
			hit_q       <= 1'b0;
			write_pos_q <= '0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						copy_q  <= cmd.copy;
						lit_q   <= cmd.lit;
						last_q  <= cmd.last;
						cnt_q   <= cmd.len;
						dist_q  <= cmd.dist_m1;
						state_q <= cmd.copy ? S_READ : S_EMIT;
					end
				end
				S_READ: begin
					hit_q   <= src_hit;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_fire) begin
						out_byte_q  <= emit_data;
						out_last_q  <= last_q && (cnt_q == LEN_W'(1));
						write_pos_q <= nwp;
						if (fill_q < FILL_W'(HIST_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						cnt_q   <= cnt_q - 1'b1;
						state_q <= (cnt_q == LEN_W'(1)) ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	`BLZ_ASSERT_IMPL(a_cnt_live, state_q != S_IDLE, cnt_q != '0, "busy with no bytes left")
	`BLZ_ASSERT_IMPL(a_fill_cap, 1'b1, fill_q <= FILL_W'(HIST_DEPTH), "fill count above depth")
	`BLZ_ASSERT_NEXT(a_wp_moves, emit_fire, write_pos_q != $past(write_pos_q), "write_pos did not step")

endmodule

[rtl/backward_lz_decompressor_core.sv]
// Backward LZ77 (BLZ) decompressor: one compressed byte in per word, decoded bytes out.
// Compressed bytes enter highest address first; decoded bytes leave highest address first,
// the last one flagged by out_last when the stream's final byte closes its token. A flag
// byte is taken with no output; a literal is accepted, then written to history and output.
// A copy token takes its high byte, then its low byte starts a copy of length 3..18; each
// copied byte needs a read step and a write step on the single history RAM port pair,
// and a stalled output holds the write step. comp_ready is low while a token is
// being emitted. History (HIST_DEPTH bytes) and its position persist between streams;
// history not yet written since reset reads as zero through a fill count, so no clearing
// pass runs after reset.
`timescale 1ns / 1ps
module backward_lz_decompressor_core
	import blz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       comp_valid,
	output logic       comp_ready,
	input  logic [7:0] comp_byte,
	input  logic       final_in,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	blz_cmd_t cmd;
	logic     idle;
	logic     fire;

	assign comp_ready = idle;
	assign fire       = comp_valid && idle;

	blz_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.comp_byte(comp_byte),
		.final_in (final_in),
		.cmd      (cmd)
	);

	blz_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idle     (idle),
		.out_byte (out_byte),
		.out_last (out_last),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

endmodule
